@@ hdl/tsp_pkg.sv @@
// package for the transport stream packet header parser
// packet geometry, sync byte and header byte positions
// no dependencies
`timescale 1ns / 1ps

package tsp_pkg;

  localparam int PACKET_BYTES = 188;
  localparam int POS_W        = 8;

  localparam logic [7:0] SYNC_MARK = 8'h47;

  // byte positions inside a packet, position 0 means hunting for sync
  localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HDR2  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_HDR3  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_ALEN  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_BYTES - 1);

  // longest adaptation field that still fits in the packet
  localparam logic [7:0] ADAPT_MAX = 8'(PACKET_BYTES - 5);

  // adaptation field control bits
  localparam int AFC_ADAPT   = 1;
  localparam int AFC_PAYLOAD = 0;

endpackage

@@ hdl/tsp_if.sv @@
// byte and result channels of the transport stream packet header parser
// depends on nothing but the clock domain of the user
`timescale 1ns / 1ps

interface tsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tsp_res_if;
  logic        valid;
  logic        ready;
  logic [12:0] pid;
  logic        unit_start;
  logic [3:0]  continuity;
  logic [1:0]  adapt_control;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        payload_first;
  logic        packet_end;
  logic        packet_error;

  modport source (
    output valid, output pid, output unit_start, output continuity,
    output adapt_control, output payload_byte, output payload_valid,
    output payload_first, output packet_end, output packet_error,
    input ready
  );
  modport sink (
    input valid, input pid, input unit_start, input continuity,
    input adapt_control, input payload_byte, input payload_valid,
    input payload_first, input packet_end, input packet_error,
    output ready
  );
endinterface

@@ hdl/ts_packet_header_parser.sv @@
// transport stream packet header parser: sync hunt, header capture,
// adaptation skip and payload tagging; uses tsp_pkg and tsp_if
//
//   channel  dir  handshake     word
//   in_s     in   valid/ready   one stream byte (in_byte)
//   out_m    out  valid/ready   pid, flags, payload byte, packet end/error
//
// one byte is taken per clock while in_s.ready is high; the packet state and
// result register update together, so a result shows the cycle after its byte.
// bytes that give no result (hunting, header, adaptation) leave out_m alone.
// in_s.ready drops only while a result is held and out_m.ready is low.
// rst_n is synchronous; after reset the parser hunts for the sync byte.
`timescale 1ns / 1ps

module ts_packet_header_parser (
  input  logic      clk,
  input  logic      rst_n,
  tsp_byte_if.sink  in_s,
  tsp_res_if.source out_m
);

  logic [tsp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [12:0] pid_r, pid_nxt;
  logic        ustart_r, ustart_nxt;
  logic [3:0]  cc_r, cc_nxt;
  logic [1:0]  afc_r, afc_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic        bad_r, bad_nxt;
  logic        seen_r, seen_nxt;

  logic        out_valid_r;
  logic [12:0] o_pid_r;
  logic        o_ustart_r;
  logic [3:0]  o_cc_r;
  logic [1:0]  o_afc_r;
  logic [7:0]  o_byte_r;
  logic        o_pvalid_r;
  logic        o_first_r;
  logic        o_end_r;
  logic        o_err_r;

  logic       in_fire;
  logic       is_payload;
  logic       is_last;
  logic       res_valid;
  logic [7:0] b;

  assign b       = in_s.in_byte;
  assign in_s.ready = !out_valid_r || out_m.ready;
  assign in_fire = in_s.valid && in_s.ready;

  always_comb begin
    pos_nxt    = pos_r;
    pid_nxt    = pid_r;
    ustart_nxt = ustart_r;
    cc_nxt     = cc_r;
    afc_nxt    = afc_r;
    skip_nxt   = skip_r;
    bad_nxt    = bad_r;
    seen_nxt   = seen_r;
    is_payload = 1'b0;
    is_last    = 1'b0;

    if (pos_r == tsp_pkg::POS_HUNT) begin
      if (b == tsp_pkg::SYNC_MARK) begin
        pos_nxt  = tsp_pkg::POS_HDR1;
        skip_nxt = 8'd0;
        bad_nxt  = 1'b0;
        seen_nxt = 1'b0;
      end
    end else begin
      priority if (pos_r == tsp_pkg::POS_HDR1) begin
        ustart_nxt = b[6];
        pid_nxt    = {b[4:0], 8'd0};
      end else if (pos_r == tsp_pkg::POS_HDR2) begin
        pid_nxt = {pid_r[12:8], b};
      end else if (pos_r == tsp_pkg::POS_HDR3) begin
        afc_nxt = b[5:4];
        cc_nxt  = b[3:0];
      end else if (pos_r == tsp_pkg::POS_ALEN && afc_r[tsp_pkg::AFC_ADAPT]) begin
        if (b > tsp_pkg::ADAPT_MAX) begin
          bad_nxt = 1'b1;
        end else begin
          skip_nxt = b;
        end
      end else if (!bad_r) begin
        if (skip_r != 8'd0) begin
          skip_nxt = skip_r - 8'd1;
        end else if (afc_r[tsp_pkg::AFC_PAYLOAD]) begin
          is_payload = 1'b1;
        end
      end else begin
        // overflowed adaptation field: rest of packet is dropped
        is_payload = 1'b0;
      end

      is_last = (pos_r >= tsp_pkg::POS_LAST);
      pos_nxt = is_last ? tsp_pkg::POS_HUNT : pos_r + tsp_pkg::POS_W'(1);
      if (is_payload) begin
        seen_nxt = 1'b1;
      end
    end
  end

  assign res_valid = is_payload || is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= tsp_pkg::POS_HUNT;
      pid_r    <= 13'd0;
      ustart_r <= 1'b0;
      cc_r     <= 4'd0;
      afc_r    <= 2'd0;
      skip_r   <= 8'd0;
      bad_r    <= 1'b0;
      seen_r   <= 1'b0;
    end else if (in_fire) begin
      pos_r    <= pos_nxt;
      pid_r    <= pid_nxt;
      ustart_r <= ustart_nxt;
      cc_r     <= cc_nxt;
      afc_r    <= afc_nxt;
      skip_r   <= skip_nxt;
      bad_r    <= bad_nxt;
      seen_r   <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word, loaded only when the accepted byte gives a result
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      o_pid_r    <= pid_nxt;
      o_ustart_r <= ustart_nxt;
      o_cc_r     <= cc_nxt;
      o_afc_r    <= afc_nxt;
      o_byte_r   <= is_payload ? b : 8'd0;
      o_pvalid_r <= is_payload;
      o_first_r  <= is_payload && !seen_r;
      o_end_r    <= is_last;
      o_err_r    <= is_last && bad_nxt;
    end
  end

  assign out_m.valid         = out_valid_r;
  assign out_m.pid           = o_pid_r;
  assign out_m.unit_start    = o_ustart_r;
  assign out_m.continuity    = o_cc_r;
  assign out_m.adapt_control = o_afc_r;
  assign out_m.payload_byte  = o_byte_r;
  assign out_m.payload_valid = o_pvalid_r;
  assign out_m.payload_first = o_first_r;
  assign out_m.packet_end    = o_end_r;
  assign out_m.packet_error  = o_err_r;

endmodule

@@ hdl/tsp_checker.sv @@
// port-level checks for ts_packet_header_parser, attached by bind
// depends on the top level's interface ports only
`timescale 1ns / 1ps

module tsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] out_pid,
  input logic [7:0]  out_payload_byte,
  input logic        out_payload_valid,
  input logic        out_payload_first,
  input logic        out_packet_end,
  input logic        out_packet_error
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pid)
      && $stable(out_payload_byte) && $stable(out_packet_end))
    else $error("result word changed while stalled");

  // every result is a payload byte or a packet end
  a_res_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload_valid || out_packet_end)
    else $error("result carries neither payload nor packet end");

  a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_error |-> out_packet_end && !out_payload_valid)
    else $error("packet error outside an end word or with payload");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_first |-> out_payload_valid)
    else $error("first flag without payload");

  // empty output stage never blocks the byte stream
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind ts_packet_header_parser tsp_checker u_tsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_s.ready),
  .out_valid         (out_m.valid),
  .out_ready         (out_m.ready),
  .out_pid           (out_m.pid),
  .out_payload_byte  (out_m.payload_byte),
  .out_payload_valid (out_m.payload_valid),
  .out_payload_first (out_m.payload_first),
  .out_packet_end    (out_m.packet_end),
  .out_packet_error  (out_m.packet_error)
);
